FILE: design/sac_pkg.sv
// Shared types, constants and the size class table of the size class block allocator.
// It depends on nothing. The other design files but sac_ram use it by scoped names.
`timescale 1ns / 1ps
package sac_pkg;

  // Arena geometry.
  localparam int ADDR_W      = 20;
  localparam int REQ_W       = 15;
  localparam int CLASS_W     = 4;
  localparam int NUM_CLASSES = 11;
  localparam int PAGE_BYTES  = 131072;
  localparam int ARENA_PAGES = 8;
  localparam int PAGES_W     = 4;
  localparam int PAGE_IDX_W  = 3;
  localparam int PAGE_OFF_W  = 17;
  localparam int OFFSET_W    = 18;
  localparam int SIZE_W      = 16;
  localparam int SLOT_SHIFT  = 3;
  localparam int HDR_IDX_W   = ADDR_W - SLOT_SHIFT;
  localparam int HDR_DEPTH   = (ARENA_PAGES * PAGE_BYTES) / 8;
  localparam int HDR_W       = 32;
  localparam int LINK_W      = 21;
  localparam int HDR_BYTES   = 4;

  localparam logic [HDR_W-1:0]   MAGIC_WORD       = 32'd52571214;
  localparam logic [PAGES_W-1:0] PAGE_LIMIT_RESET = 4'd8;

  // Register index, taken from the word address.
  localparam logic [0:0] REG_PAGE_LIMIT = 1'b0;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [REQ_W-1:0]  req_bytes;
    logic [ADDR_W-1:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  block_addr;
    logic [CLASS_W-1:0] size_class;
    status_e            status;
  } out_item_t;

  // Classified request as it waits between the front and the back.
  typedef struct packed {
    op_e                op;
    logic [CLASS_W-1:0] cls;
    logic               too_large;
    logic               foreign;
    logic [ADDR_W-1:0]  free_addr;
  } work_t;

  // Block size of each class, header included.
  function automatic logic [SIZE_W-1:0] class_size(input logic [CLASS_W-1:0] cls);
    logic [SIZE_W-1:0] sz;
    unique case (cls)
      4'd0:    sz = 16'd16;
      4'd1:    sz = 16'd32;
      4'd2:    sz = 16'd64;
      4'd3:    sz = 16'd128;
      4'd4:    sz = 16'd256;
      4'd5:    sz = 16'd1024;
      4'd6:    sz = 16'd2048;
      4'd7:    sz = 16'd4096;
      4'd8:    sz = 16'd8192;
      4'd9:    sz = 16'd16384;
      4'd10:   sz = 16'd32704;
      default: sz = '0;
    endcase
    return sz;
  endfunction

endpackage

FILE: design/sac_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing.
`timescale 1ns / 1ps
module sac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sac_front.sv
// Front end: takes input words, picks the size class and checks the freed address.
// It depends on sac_pkg.
`timescale 1ns / 1ps
module sac_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sac_pkg::in_item_t in_data_i,
  input  logic              q_full_i,
  output logic              push_o,
  output sac_pkg::work_t    push_data_o
);

  logic [sac_pkg::SIZE_W-1:0]      need;
  logic [sac_pkg::NUM_CLASSES-1:0] fits;

  // Classes grow monotonically, so the class index is the number of classes too small.
  always_comb begin
    need = sac_pkg::SIZE_W'(in_data_i.req_bytes) + sac_pkg::SIZE_W'(sac_pkg::HDR_BYTES);
    for (int c = 0; c < sac_pkg::NUM_CLASSES; c++) begin
      fits[c] = (need <= sac_pkg::class_size(sac_pkg::CLASS_W'(c)));
    end
  end

  always_comb begin
    push_data_o.op        = in_data_i.op;
    push_data_o.cls       = sac_pkg::CLASS_W'($countones(~fits));
    push_data_o.too_large = ~fits[sac_pkg::NUM_CLASSES-1];
    // A payload address sits four bytes past an 8-byte slot boundary.
    push_data_o.foreign   = (in_data_i.free_addr[sac_pkg::SLOT_SHIFT-1:0] != 3'd4);
    push_data_o.free_addr = in_data_i.free_addr;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

FILE: design/sac_queue.sv
// Short FIFO of classified requests between the front end and the back end.
// It depends on sac_pkg.
`timescale 1ns / 1ps
module sac_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sac_pkg::work_t push_data_i,
  input  logic           pop_i,
  output sac_pkg::work_t pop_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  sac_pkg::work_t  entry_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = entry_q[rd_ptr_q];
  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);

endmodule

FILE: design/sac_back.sv
// Back end: free list heads, page bump pointer and the block header memory.
// It depends on sac_pkg and sac_ram.
`timescale 1ns / 1ps
module sac_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          queue_empty_i,
  input  sac_pkg::work_t                work_i,
  output logic                          pop_o,
  input  logic [sac_pkg::PAGES_W-1:0]   page_limit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sac_pkg::out_item_t            out_data_o
);

  localparam int AW = sac_pkg::ADDR_W;
  localparam int SS = sac_pkg::SLOT_SHIFT;

  sac_pkg::back_state_e state_q, state_d;
  logic                 pop, exec;

  sac_pkg::work_t                 work_q;
  logic [sac_pkg::LINK_W-1:0]     head_q, head_sel;
  logic [sac_pkg::LINK_W-1:0]     heads_q [sac_pkg::NUM_CLASSES];
  logic                           head_we;
  logic [sac_pkg::LINK_W-1:0]     head_wdata;
  logic [sac_pkg::PAGES_W-1:0]    pages_open_q, pages_open_d, limit;
  logic [sac_pkg::OFFSET_W-1:0]   bump_q, bump_d, sz;
  logic [sac_pkg::OFFSET_W:0]     bump_sum;
  logic                           new_page;
  logic [sac_pkg::PAGE_IDX_W-1:0] page_idx;
  logic [sac_pkg::PAGE_OFF_W-1:0] page_off;
  logic [AW-1:0]                  bump_blk;

  logic                           out_valid_q, out_valid_d;
  sac_pkg::out_item_t             out_q, res;

  logic                           ram_we;
  logic [sac_pkg::HDR_IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [sac_pkg::HDR_W-1:0]      ram_wdata, ram_rdata;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sac_pkg::BK_IDLE: if (pop) begin
        state_d = sac_pkg::BK_EXEC;
      end
      sac_pkg::BK_EXEC: state_d = sac_pkg::BK_IDLE;
      default:          state_d = sac_pkg::BK_IDLE;
    endcase
  end

  // State outputs: a request is taken only when the result slot will be free.
  always_comb begin
    pop  = 1'b0;
    exec = 1'b0;
    unique case (state_q)
      sac_pkg::BK_IDLE: pop  = !queue_empty_i && (!out_valid_q || !out_stall_i);
      sac_pkg::BK_EXEC: exec = 1'b1;
      default: ;
    endcase
  end

  // Read side: the header of the freed block or of the list head is fetched on pop.
  always_comb begin
    head_sel  = (work_i.cls < sac_pkg::CLASS_W'(sac_pkg::NUM_CLASSES)) ?
                heads_q[work_i.cls] : '0;
    ram_raddr = (work_i.op == sac_pkg::OP_FREE) ? work_i.free_addr[AW-1:SS] : head_sel[AW-1:SS];
  end

  // Bump allocation from the current page.
  always_comb begin
    sz       = sac_pkg::OFFSET_W'(sac_pkg::class_size(work_q.cls));
    bump_sum = (sac_pkg::OFFSET_W+1)'(bump_q) + (sac_pkg::OFFSET_W+1)'(sz);
    new_page = (pages_open_q == '0) ||
               (bump_sum > (sac_pkg::OFFSET_W+1)'(sac_pkg::PAGE_BYTES));
    limit    = (page_limit_i > sac_pkg::PAGES_W'(sac_pkg::ARENA_PAGES)) ?
               sac_pkg::PAGES_W'(sac_pkg::ARENA_PAGES) : page_limit_i;
    page_idx = new_page ? pages_open_q[sac_pkg::PAGE_IDX_W-1:0] :
               sac_pkg::PAGE_IDX_W'(pages_open_q - 1'b1);
    page_off = new_page ? '0 : bump_q[sac_pkg::PAGE_OFF_W-1:0];
    bump_blk = {page_idx, page_off};
  end

  // Execute step: settle the result and the state updates.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = work_q.free_addr[AW-1:SS];
    ram_wdata       = sac_pkg::MAGIC_WORD;
    head_we         = 1'b0;
    head_wdata      = head_q;
    pages_open_d    = pages_open_q;
    bump_d          = bump_q;
    res.block_addr  = '0;
    res.size_class  = '0;
    res.status      = sac_pkg::ST_OK;
    if (exec) begin
      if (work_q.op == sac_pkg::OP_ALLOC) begin
        if (work_q.too_large) begin
          res.status = sac_pkg::ST_TOO_LARGE;
        end else if (head_q[sac_pkg::LINK_W-1]) begin
          // Pop the list: the header of the head block links to the next one.
          head_we        = 1'b1;
          head_wdata     = ram_rdata[sac_pkg::LINK_W-1:0];
          ram_we         = 1'b1;
          ram_waddr      = head_q[AW-1:SS];
          res.block_addr = head_q[AW-1:0] + AW'(sac_pkg::HDR_BYTES);
          res.size_class = work_q.cls;
        end else if (new_page && (pages_open_q >= limit)) begin
          res.status = sac_pkg::ST_EXHAUSTED;
        end else begin
          pages_open_d   = new_page ? pages_open_q + 1'b1 : pages_open_q;
          bump_d         = new_page ? sz : bump_sum[sac_pkg::OFFSET_W-1:0];
          ram_we         = 1'b1;
          ram_waddr      = bump_blk[AW-1:SS];
          res.block_addr = bump_blk + AW'(sac_pkg::HDR_BYTES);
          res.size_class = work_q.cls;
        end
      end else begin
        if (work_q.foreign || (ram_rdata != sac_pkg::MAGIC_WORD)) begin
          res.status = sac_pkg::ST_BAD_MAGIC;
        end else if (work_q.too_large) begin
          res.status = sac_pkg::ST_TOO_LARGE;
        end else begin
          // Push: the header takes the old head, the block becomes the head.
          ram_we         = 1'b1;
          ram_wdata      = sac_pkg::HDR_W'(head_q);
          head_we        = 1'b1;
          head_wdata     = {1'b1, work_q.free_addr[AW-1:SS], {SS{1'b0}}};
          res.size_class = work_q.cls;
        end
      end
    end
  end

  always_comb begin
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sac_pkg::BK_IDLE;
      out_valid_q  <= 1'b0;
      pages_open_q <= '0;
      bump_q       <= '0;
      for (int c = 0; c < sac_pkg::NUM_CLASSES; c++) begin
        heads_q[c] <= '0;
      end
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      pages_open_q <= pages_open_d;
      bump_q       <= bump_d;
      if (head_we) begin
        heads_q[work_q.cls] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      work_q <= work_i;
      head_q <= head_sel;
    end
    if (exec) begin
      out_q <= res;
    end
  end

  sac_ram #(
    .WIDTH(sac_pkg::HDR_W),
    .DEPTH(sac_pkg::HDR_DEPTH)
  ) u_hdr_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (pop),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/size_class_block_allocator_core.sv
// Top level of the size class block allocator: configuration port, front end, queue, back end.
// It depends on sac_pkg, sac_front, sac_queue and sac_back.
`timescale 1ns / 1ps
// Usage: the block hands out and takes back blocks of an arena of eight 128 KiB pages in
// eleven size classes. Each input word (in_valid_i / in_stall_o / in_data_i) is an
// allocate or a free; each one yields exactly one result word (out_valid_o / out_stall_i /
// out_data_o) with the payload address, the class and a status, in request order.
// A word is moved at a rising edge where valid is high and stall is low.
// The front end classifies a request in the cycle it is accepted and drops it into a short
// queue. The back end takes each request through BK_IDLE, whose pop starts the synchronous
// read of the block header memory, and BK_EXEC, which checks it, updates the free list head
// or bump pointer, writes the header back and loads the result register. It takes no new
// request before it is through with the last, as the header memory is read and then written.
// With an idle block a request passes the queue, BK_IDLE and BK_EXEC before the result
// register shows it. If the receiver stalls, the result register holds its word; the back
// end stops and the queue fills, after which in_stall_o rises. Reset empties the queue and
// the result register, empties every free list, closes all pages and sets page_limit to
// eight. The header memory is not cleared; no clearing pass is needed. page_limit sits at
// byte address 0 of the configuration port and should only be written while the block is idle.
module size_class_block_allocator_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Request channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sac_pkg::in_item_t  in_data_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sac_pkg::out_item_t out_data_o
);

  logic [sac_pkg::PAGES_W-1:0] page_limit_q;
  logic                        cfg_write;

  logic           q_push, q_pop, q_full, q_empty;
  sac_pkg::work_t q_push_data, q_head;

  // The register index is the word address; the byte lane bits are ignored.
  assign cfg_write = psel && penable && pwrite && (paddr[2] == sac_pkg::REG_PAGE_LIMIT);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == sac_pkg::REG_PAGE_LIMIT) ? 32'(page_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_limit_q <= sac_pkg::PAGE_LIMIT_RESET;
    end else if (cfg_write) begin
      page_limit_q <= pwdata[sac_pkg::PAGES_W-1:0];
    end
  end

  // Front end: class selection and address checks happen as the word is accepted.
  sac_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_data_o(q_push_data)
  );

  // Decouples the two sides so a stalled result does not block acceptance at once.
  sac_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .pop_i      (q_pop),
    .pop_data_o (q_head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // Back end: free lists, page bump pointer, header memory and the result register.
  sac_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .queue_empty_i(q_empty),
    .work_i       (q_head),
    .pop_o        (q_pop),
    .page_limit_i (page_limit_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: design/sac_checker.sv
// Port-level checks of the size class block allocator, bound to its top level.
// It depends on sac_pkg and size_class_block_allocator_core.
`timescale 1ns / 1ps
module sac_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_stall,
  input sac_pkg::out_item_t out_data
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every failed request reports neither an address nor a class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data.status != sac_pkg::ST_OK) |->
      (out_data.block_addr == '0) && (out_data.size_class == '0))
    else $error("error result carries an address or class");

  // Handed out addresses lie four bytes into an 8-byte slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data.status == sac_pkg::ST_OK) && (out_data.block_addr != '0) |->
      (out_data.block_addr[2:0] == 3'd4))
    else $error("misaligned block address");

  // The back end reads the header, then executes, so a taken result is never followed at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_stall |=> !out_valid)
    else $error("results closer than two cycles");

  // Nothing is offered right after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid)
    else $error("result valid out of reset");

endmodule

bind size_class_block_allocator_core sac_checker u_sac_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_valid_o),
  .out_stall(out_stall_i),
  .out_data (out_data_o)
);

FILE: dv/sac_alloc_checker.sv
// Checker for the size class block allocator: watches the configuration port and both word
// channels, predicts every result and compares it field by field. It depends on sac_pkg.
`timescale 1ns / 1ps
module sac_alloc_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               req_valid_i,
  input  logic               req_stall_i,
  input  sac_pkg::in_item_t  req_word_i,
  input  logic               rsp_valid_i,
  input  logic               rsp_stall_i,
  input  sac_pkg::out_item_t rsp_word_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import sac_pkg::*;

  localparam int unsigned SLOTS      = HDR_DEPTH;
  localparam int unsigned PAGE       = PAGE_BYTES;
  localparam logic [20:0] LINK_VALID = 21'h100000;
  localparam int unsigned CLASS_TOP [NUM_CLASSES] = '{
    16, 32, 64, 128, 256, 1024, 2048, 4096, 8192, 16384, 32704
  };

  // Own copy of the allocator state.
  logic [20:0]    list_heads [NUM_CLASSES];
  bit   [31:0]    hdr_words  [SLOTS];
  int unsigned    pages_used = 0;
  int unsigned    bump_ofs   = 0;
  logic [3:0]     limit_reg  = 4'd8;

  out_item_t      due_results [$];
  int             fails     = 0;
  int             due_count = 0;

  assign fail_count_o = fails;
  assign pending_o    = due_count;

  function automatic int class_for_need(input int unsigned need);
    int c;
    class_for_need = -1;
    for (c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (need <= CLASS_TOP[c]) class_for_need = c;
    end
  endfunction

  // Applies one request to the local state and returns the result word it should produce.
  function automatic out_item_t serve_request(input in_item_t w);
    out_item_t   r;
    int          c;
    int unsigned sz;
    int unsigned blk;
    int unsigned idx;
    int unsigned lim;
    r.block_addr = '0;
    r.size_class = '0;
    r.status     = ST_OK;
    if (w.op == OP_ALLOC) begin
      c = class_for_need(int'(w.req_bytes) + HDR_BYTES);
      if (c < 0) begin
        r.status = ST_TOO_LARGE;
        return r;
      end
      sz = CLASS_TOP[c];
      if (list_heads[c][20]) begin
        // Reuse the most recently freed block of this class.
        blk = int'(list_heads[c][19:0]);
        idx = blk >> 3;
        list_heads[c]  = hdr_words[idx][20:0];
        hdr_words[idx] = MAGIC_WORD;
      end else begin
        if (pages_used == 0 || bump_ofs + sz > PAGE) begin
          lim = (limit_reg > 4'd8) ? 8 : int'(limit_reg);
          if (pages_used >= lim) begin
            r.status = ST_EXHAUSTED;
            return r;
          end
          pages_used++;
          bump_ofs = 0;
        end
        blk = (pages_used - 1) * PAGE + bump_ofs;
        bump_ofs += sz;
        hdr_words[blk >> 3] = MAGIC_WORD;
      end
      r.block_addr = 20'(blk + HDR_BYTES);
      r.size_class = 4'(c);
    end else begin
      if (w.free_addr < 20'(HDR_BYTES)) begin
        r.status = ST_BAD_MAGIC;
        return r;
      end
      blk = int'(w.free_addr) - HDR_BYTES;
      idx = blk >> 3;
      if ((blk % 8) != 0 || idx >= SLOTS || hdr_words[idx] != MAGIC_WORD) begin
        r.status = ST_BAD_MAGIC;
        return r;
      end
      c = class_for_need(int'(w.req_bytes) + HDR_BYTES);
      if (c < 0) begin
        r.status = ST_TOO_LARGE;
        return r;
      end
      hdr_words[idx] = {11'd0, list_heads[c]};
      list_heads[c]  = LINK_VALID | 21'(blk);
      r.size_class   = 4'(c);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_word;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLASSES; i++) list_heads[i] = '0;
      pages_used = 0;
      bump_ofs   = 0;
      limit_reg  = PAGE_LIMIT_RESET;
      due_results.delete();
      due_count = 0;
    end else begin
      if (psel && penable && pready && paddr[2] == REG_PAGE_LIMIT) begin
        if (pwrite) begin
          limit_reg = pwdata[3:0];
        end else if (prdata != {28'd0, limit_reg}) begin
          $display("%0t: page_limit read expected %h actual %h", $time,
                   {28'd0, limit_reg}, prdata);
          fails++;
        end
      end
      if (req_valid_i && !req_stall_i) due_results.push_back(serve_request(req_word_i));
      if (rsp_valid_i && !rsp_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word with none expected, actual addr %h class %0d status %0d",
                   $time, rsp_word_i.block_addr, rsp_word_i.size_class, rsp_word_i.status);
          fails++;
        end else begin
          exp_word = due_results.pop_front();
          if (rsp_word_i.block_addr != exp_word.block_addr) begin
            $display("%0t: block_addr expected %h actual %h", $time,
                     exp_word.block_addr, rsp_word_i.block_addr);
            fails++;
          end
          if (rsp_word_i.size_class != exp_word.size_class) begin
            $display("%0t: size_class expected %0d actual %0d", $time,
                     exp_word.size_class, rsp_word_i.size_class);
            fails++;
          end
          if (rsp_word_i.status != exp_word.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_word.status, rsp_word_i.status);
            fails++;
          end
        end
      end
      due_count = due_results.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top of the size class block allocator: clock, reset, stimulus and the verdict.
// It depends on sac_pkg, size_class_block_allocator_core and sac_alloc_checker.
`timescale 1ns / 1ps
module tb_top;
  import sac_pkg::*;

  // A watchdog ends the run when no word, and no register access, moves for this many
  // cycles. The slowest legal pause is the long receiver hold plus a few stalls.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 72;

  localparam logic [2:0] PAGE_LIMIT_ADDR = {REG_PAGE_LIMIT, 2'b00};

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [CLASS_W-1:0] cls;
  } live_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  int          alloc_failures;
  int          results_due;
  int          quiet_cycles = 0;

  // Addresses handed out so far, with their class. Every one of them has a header that
  // has been written, so freeing any of them stays inside the contract of the block.
  live_t       live_q [$];

  // Idling controls, set per phase by the stimulus process.
  bit          tx_idle     = 1'b0;
  bit          rx_idle     = 1'b1;
  bit          rx_hold_req = 1'b0;

  size_class_block_allocator_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  sac_alloc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .req_valid_i  (in_valid_i),
    .req_stall_i  (in_stall_o),
    .req_word_i   (in_data_i),
    .rsp_valid_i  (out_valid_o),
    .rsp_stall_i  (out_stall_i),
    .rsp_word_i   (out_data_o),
    .fail_count_o (alloc_failures),
    .pending_o    (results_due)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Collect every successfully allocated address as it leaves the block.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i && out_data_o.status == ST_OK &&
        out_data_o.block_addr != '0) begin
      live_q.push_back({out_data_o.block_addr, out_data_o.size_class});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver. It stalls in random runs, mostly short ones, and on request holds off for a
  // long stretch so that the result register and the queue fill and in_stall_o rises.
  initial begin
    int rx_run;
    bit rx_level;
    rx_run   = 0;
    rx_level = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk_i);
        rx_hold_req = 1'b0;
        rx_run      = 0;
      end else if (rx_idle) begin
        if (rx_run == 0) begin
          rx_level = ($urandom_range(99) < 35);
          if (!rx_level) begin
            rx_run = $urandom_range(8, 1);
          end else if ($urandom_range(99) < 85) begin
            rx_run = $urandom_range(3, 1);
          end else begin
            rx_run = $urandom_range(30, 5);
          end
        end
        out_stall_i <= rx_level;
        rx_run--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offers one word and holds it until it is taken, then leaves an optional gap.
  task automatic send_word(input op_e op, input int req, input logic [ADDR_W-1:0] addr);
    in_item_t w;
    int       gap;
    w.op        = op;
    w.req_bytes = REQ_W'(req);
    w.free_addr = addr;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stops offering words and waits until every expected result has been taken.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PAGE_LIMIT_ADDR;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes page_limit and reads it back; the checker compares the read data.
  task automatic set_page_limit(input int lim);
    apb_access(1'b1, 32'(lim));
    apb_access(1'b0, 32'd0);
  endtask

  // Random request size: mostly small, some medium, a few in the three largest classes and a
  // few beyond the largest.
  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(252, 0);
    if (r < 90) return $urandom_range(4092, 253);
    if (r < 97) return $urandom_range(32700, 4093);
    return $urandom_range(32767, 32701);
  endfunction

  task automatic send_random_word();
    int          r;
    int          k;
    int          c;
    int          lo;
    int          hi;
    int          req;
    live_t       pick;
    logic [31:0] raw;
    r   = $urandom_range(99);
    raw = $urandom;
    if (r < 55 || live_q.size() == 0) begin
      send_word(OP_ALLOC, pick_size(), raw[ADDR_W-1:0]);
    end else if (r < 88) begin
      // Free of a handed-out block. Mostly the size matches its class; sometimes it
      // selects another class or is too large. Leaving the entry in the list now and
      // then produces double frees later on.
      k    = $urandom_range(live_q.size() - 1);
      pick = live_q[k];
      if ($urandom_range(99) < 85) live_q.delete(k);
      c = (pick.cls > 4'd10) ? 10 : int'(pick.cls);
      r = $urandom_range(99);
      if (r < 80) begin
        lo  = (c == 0) ? 0 : int'(class_size(CLASS_W'(c - 1))) - 3;
        hi  = int'(class_size(CLASS_W'(c))) - 4;
        req = $urandom_range(hi, lo);
      end else if (r < 95) begin
        req = pick_size();
      end else begin
        req = $urandom_range(32767, 32701);
      end
      send_word(OP_FREE, req, pick.addr);
    end else begin
      // Foreign address: never four past a slot boundary, so no unwritten header is read.
      if (raw[2:0] == 3'd4) raw[0] = ~raw[0];
      send_word(OP_FREE, $urandom_range(32767, 0), raw[ADDR_W-1:0]);
    end
  endtask

  initial begin
    int                phase_limit [PHASES];
    bit                phase_tx    [PHASES];
    bit                phase_rx    [PHASES];
    logic [ADDR_W-1:0] first_addr;
    phase_limit = '{3, 8, 15, 9, 2, 8};
    phase_tx    = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    phase_rx    = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // With a limit of zero no page can open, so any bump allocation is exhausted.
    set_page_limit(0);
    send_word(OP_ALLOC, 12, 20'h00000);
    send_word(OP_FREE, 0, 20'h00000);
    settle();

    // Directed part on a single page: class edges, too large requests and foreign frees.
    set_page_limit(1);
    send_word(OP_ALLOC, 0, 20'hFFFFF);
    send_word(OP_ALLOC, 12, 20'h00000);
    send_word(OP_ALLOC, 13, 20'h55555);
    send_word(OP_ALLOC, 32700, 20'hAAAAA);
    send_word(OP_ALLOC, 32701, 20'h00000);
    send_word(OP_ALLOC, 32767, 20'hFFFFF);
    send_word(OP_FREE, 0, 20'h00000);
    send_word(OP_FREE, 0, 20'h00003);
    send_word(OP_FREE, 0, 20'h00005);
    send_word(OP_FREE, 32767, 20'hFFFFF);
    settle();

    // Free, double free, reuse, free with a too large size and free into another class.
    first_addr = (live_q.size() != 0) ? live_q[0].addr : 20'd4;
    send_word(OP_FREE, 0, first_addr);
    send_word(OP_FREE, 0, first_addr);
    send_word(OP_ALLOC, 0, 20'h00000);
    send_word(OP_FREE, 32701, first_addr);
    send_word(OP_FREE, 100, first_addr);
    send_word(OP_ALLOC, 100, 20'h00000);

    // Fill the only page with the largest class until the arena runs out.
    repeat (4) send_word(OP_ALLOC, 32700, 20'h00000);
    settle();

    // A second page opens; the tail of the first one is wasted.
    set_page_limit(2);
    send_word(OP_ALLOC, 32700, 20'h00000);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_page_limit(phase_limit[p]);
      tx_idle = phase_tx[p];
      rx_idle = phase_rx[p];
      // In the second phase the receiver holds off while words keep coming.
      if (p == 1) rx_hold_req = 1'b1;
      repeat (PHASE_WORDS) send_random_word();
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (alloc_failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sac_pkg.sv
design/sac_ram.sv
design/sac_front.sv
design/sac_queue.sv
design/sac_back.sv
design/size_class_block_allocator_core.sv
design/sac_checker.sv
dv/sac_alloc_checker.sv
dv/tb_top.sv
